[hw/rtl/pbvh_pkg.sv]
package pbvh_pkg;

  // Field widths fixed by the interface.
  localparam int PRICE_W  = 24;
  localparam int QTY_W    = 16;
  localparam int RIDX_W   = 8;
  localparam int BUCKET_W = 8;
  localparam int TOTAL_W  = 40;

  localparam int BUCKET_COUNT_DEF     = 256;
  localparam int UNITS_PER_BUCKET_DEF = 100;

  localparam logic [PRICE_W-1:0] BASE_PRICE_RST = 24'd990000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

endpackage

[hw/rtl/price_bucket_volume_histogram_top.sv]
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    operation, side, quantity, price, read_index
// out_     output     out_valid/out_stall  bucket, total, saturated
// cfg_     input      cfg_we               cfg_wdata -> base_price
//
// One beat per cycle sustained while out_stall is low; a result passes in order through
// the stages (input register, product, bucket/RAM read, update, output register).
// The bucket totals live in one RAM (buy half, sell half) with one write and one read port;
// a one-deep forward path covers an update to the bucket that the next beat reads.
// After reset a clearing pass zeroes all 2**(clog2(BUCKET_COUNT)+1) RAM words,
// with in_stall high; cfg writes are taken as ever.
// out_stall freezes the output register; upstream stages keep filling bubbles.
module price_bucket_volume_histogram_top #(
  parameter int BUCKET_COUNT     = pbvh_pkg::BUCKET_COUNT_DEF,
  parameter int UNITS_PER_BUCKET = pbvh_pkg::UNITS_PER_BUCKET_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_we,
  input  logic [pbvh_pkg::PRICE_W-1:0] cfg_wdata,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic                         in_side,
  input  logic [pbvh_pkg::QTY_W-1:0]   in_quantity,
  input  logic [pbvh_pkg::PRICE_W-1:0] in_price,
  input  logic [pbvh_pkg::RIDX_W-1:0]  in_read_index,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbvh_pkg::BUCKET_W-1:0] out_bucket,
  output logic [pbvh_pkg::TOTAL_W-1:0]  out_total,
  output logic                          out_saturated
);

  localparam int TW = pbvh_pkg::TOTAL_W;
  localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int BW = (AW > pbvh_pkg::RIDX_W) ? AW : pbvh_pkg::RIDX_W;
  localparam int RAM_DEPTH = 2 ** (AW + 1);

  // Rounded bucket = (2*diff + U) / (2*U), done as a multiply by an exact reciprocal.
  localparam int NW = $clog2(2 * (2 ** pbvh_pkg::PRICE_W - 1) + UNITS_PER_BUCKET + 1);
  localparam int DIVISOR = 2 * UNITS_PER_BUCKET;
  localparam int LW = $clog2(DIVISOR);
  localparam int SHIFT = NW + LW;
  localparam int MW = NW + 2;
  localparam int PW = NW + MW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];
  localparam logic [PW-1:0] LAST_BUCKET_P = PW'(BUCKET_COUNT - 1);
  localparam logic [AW-1:0] LAST_BUCKET_A = AW'(BUCKET_COUNT - 1);

  // ---------------- configuration ----------------
  logic [pbvh_pkg::PRICE_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= pbvh_pkg::BASE_PRICE_RST;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // ---------------- clearing pass ----------------
  logic          clear_r;
  logic [AW:0]   clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clear_r <= 1'b0;
      end
    end
  end

  // ---------------- stage control ----------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic mv1, mv2, mv3, mv4, in_acc;

  // mvN: stage N hands its beat on this edge.
  assign mv4    = v4_r && (!out_valid_r || !out_stall);
  assign mv3    = v3_r && (!v4_r || mv4);
  assign mv2    = v2_r && (!v3_r || mv3);
  assign mv1    = v1_r && (!v2_r || mv2);
  assign in_stall = clear_r || (v1_r && !mv1);
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (mv1) begin
        v1_r <= 1'b0;
      end
      if (mv1) begin
        v2_r <= 1'b1;
      end else if (mv2) begin
        v2_r <= 1'b0;
      end
      if (mv2) begin
        v3_r <= 1'b1;
      end else if (mv3) begin
        v3_r <= 1'b0;
      end
      if (mv3) begin
        v4_r <= 1'b1;
      end else if (mv4) begin
        v4_r <= 1'b0;
      end
      if (mv4) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 1: input register, offset from base ----------------
  pbvh_pkg::op_t                op1_r;
  pbvh_pkg::side_t              side1_r;
  logic [pbvh_pkg::QTY_W-1:0]   qty1_r;
  logic [pbvh_pkg::PRICE_W-1:0] price1_r;
  logic [pbvh_pkg::RIDX_W-1:0]  ridx1_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op1_r    <= pbvh_pkg::op_t'(in_operation);
      side1_r  <= pbvh_pkg::side_t'(in_side);
      qty1_r   <= in_quantity;
      price1_r <= in_price;
      ridx1_r  <= in_read_index;
    end
  end

  logic [pbvh_pkg::PRICE_W-1:0] diff1;
  logic [NW-1:0]                num1;
  logic                         below1;

  assign below1 = price1_r < base_r;
  assign diff1  = price1_r - base_r;
  assign num1   = NW'({diff1, 1'b0}) + NW'(UNITS_PER_BUCKET);

  // ---------------- stage 2: reciprocal multiply ----------------
  pbvh_pkg::op_t               op2_r;
  pbvh_pkg::side_t             side2_r;
  logic [pbvh_pkg::QTY_W-1:0]  qty2_r;
  logic [pbvh_pkg::RIDX_W-1:0] ridx2_r;
  logic                        below2_r;
  logic [NW-1:0]               num2_r;

  always_ff @(posedge clk) begin
    if (mv1) begin
      op2_r    <= op1_r;
      side2_r  <= side1_r;
      qty2_r   <= qty1_r;
      ridx2_r  <= ridx1_r;
      below2_r <= below1;
      num2_r   <= num1;
    end
  end

  logic [PW-1:0] prod2;
  assign prod2 = PW'(num2_r) * PW'(RECIP);

  // ---------------- stage 3: clamp, pick address, issue RAM read ----------------
  pbvh_pkg::op_t               op3_r;
  pbvh_pkg::side_t             side3_r;
  logic [pbvh_pkg::QTY_W-1:0]  qty3_r;
  logic [pbvh_pkg::RIDX_W-1:0] ridx3_r;
  logic                        below3_r;
  logic [PW-1:0]               prod3_r;

  always_ff @(posedge clk) begin
    if (mv2) begin
      op3_r    <= op2_r;
      side3_r  <= side2_r;
      qty3_r   <= qty2_r;
      ridx3_r  <= ridx2_r;
      below3_r <= below2_r;
      prod3_r  <= prod2;
    end
  end

  logic [PW-1:0]               quo3;
  logic [AW-1:0]               add_bkt3;
  logic [BW-1:0]               add_bkt_w3;
  logic [BW-1:0]               ridx_w3;
  logic                        rd_ok3;
  logic [AW-1:0]               addr3;
  logic [pbvh_pkg::BUCKET_W-1:0] bkt3;

  always_comb begin
    quo3 = prod3_r >> SHIFT;
    if (below3_r) begin
      add_bkt3 = '0;
    end else if (quo3 > LAST_BUCKET_P) begin
      add_bkt3 = LAST_BUCKET_A;
    end else begin
      add_bkt3 = quo3[AW-1:0];
    end
    add_bkt_w3 = BW'(add_bkt3);
    ridx_w3    = BW'(ridx3_r);
    rd_ok3     = {1'b0, ridx_w3} < (BW + 1)'(BUCKET_COUNT);
    unique case (op3_r)
      pbvh_pkg::OP_READ: begin
        addr3 = ridx_w3[AW-1:0];
        bkt3  = ridx3_r;
      end
      pbvh_pkg::OP_ADD: begin
        addr3 = add_bkt3;
        bkt3  = add_bkt_w3[pbvh_pkg::BUCKET_W-1:0];
      end
      default: begin
        addr3 = add_bkt3;
        bkt3  = add_bkt_w3[pbvh_pkg::BUCKET_W-1:0];
      end
    endcase
  end

  // ---------------- stage 4: read-modify-write ----------------
  pbvh_pkg::op_t                 op4_r;
  pbvh_pkg::side_t               side4_r;
  logic [pbvh_pkg::QTY_W-1:0]    qty4_r;
  logic [AW-1:0]                 addr4_r;
  logic [pbvh_pkg::BUCKET_W-1:0] bkt4_r;
  logic                          rd_ok4_r;
  logic                          hit4_r;
  logic [TW-1:0]                 fwd4_r;

  logic [TW-1:0] rdata4;
  logic [TW-1:0] cur4;
  logic [TW:0]   sum4;
  logic [TW-1:0] new_tot4;
  logic [TW-1:0] res_tot4;
  logic          hit_nxt;

  assign cur4     = hit4_r ? fwd4_r : rdata4;
  assign sum4     = {1'b0, cur4} + (TW + 1)'(qty4_r);
  assign new_tot4 = sum4[TW] ? pbvh_pkg::TOTAL_MAX : sum4[TW-1:0];

  always_comb begin
    unique case (op4_r)
      pbvh_pkg::OP_ADD:  res_tot4 = new_tot4;
      pbvh_pkg::OP_READ: res_tot4 = rd_ok4_r ? cur4 : '0;
      default:           res_tot4 = new_tot4;
    endcase
  end

  // The RAM misses a write landing on the edge of this read: catch it here.
  assign hit_nxt = mv4 && (op4_r == pbvh_pkg::OP_ADD) && (side4_r == side3_r)
                   && (addr4_r == addr3);

  always_ff @(posedge clk) begin
    if (mv3) begin
      op4_r    <= op3_r;
      side4_r  <= side3_r;
      qty4_r   <= qty3_r;
      addr4_r  <= addr3;
      bkt4_r   <= bkt3;
      rd_ok4_r <= rd_ok3;
      hit4_r   <= hit_nxt;
      fwd4_r   <= new_tot4;
    end
  end

  logic          ram_we;
  logic [AW:0]   ram_waddr;
  logic [TW-1:0] ram_wdata;

  always_comb begin
    if (clear_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = mv4 && (op4_r == pbvh_pkg::OP_ADD);
      ram_waddr = {side4_r, addr4_r};
      ram_wdata = new_tot4;
    end
  end

  pbvh_ram #(
    .WIDTH (TW),
    .DEPTH (RAM_DEPTH)
  ) u_totals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (mv3),
    .raddr ({side3_r, addr3}),
    .rdata (rdata4)
  );

  // ---------------- output register ----------------
  logic [pbvh_pkg::BUCKET_W-1:0] out_bkt_r;
  logic [TW-1:0]                 out_tot_r;
  logic                          out_sat_r;

  // Hold while stalled; load a new beat when the register frees up.
  always_ff @(posedge clk) begin
    if (mv4) begin
      out_bkt_r <= bkt4_r;
      out_tot_r <= res_tot4;
      out_sat_r <= (res_tot4 == pbvh_pkg::TOTAL_MAX);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bucket    = out_bkt_r;
  assign out_total     = out_tot_r;
  assign out_saturated = out_sat_r;

  // ---------------- assertions ----------------
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> in_stall)
    else $error("input accepted during clearing pass");

  a_pipe_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !v4_r)
    else $error("update stage busy during clearing pass");

  a_oob_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mv4 && op4_r == pbvh_pkg::OP_READ && !rd_ok4_r) |=> (out_total == '0 && !out_saturated))
    else $error("out-of-range read returned nonzero total");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mv4 && op4_r == pbvh_pkg::OP_ADD && cur4 == pbvh_pkg::TOTAL_MAX) |=> out_saturated)
    else $error("saturated total lost saturation on add");

endmodule

[hw/rtl/pbvh_ram.sv]
module pbvh_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[test/tb_price_bucket_volume_histogram_top.sv]
`timescale 1ns / 100ps

module tb_price_bucket_volume_histogram_top;

  localparam int BUCKETS = pbvh_pkg::BUCKET_COUNT_DEF;
  localparam int UNITS   = pbvh_pkg::UNITS_PER_BUCKET_DEF;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PIPE_CYCLES = 8;
  localparam logic [pbvh_pkg::PRICE_W-1:0] BASE_RST = pbvh_pkg::BASE_PRICE_RST;

  // One expected result beat.
  typedef struct packed {
    logic [pbvh_pkg::BUCKET_W-1:0] bucket;
    logic [pbvh_pkg::TOTAL_W-1:0]  total;
    logic                          saturated;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_we = 1'b0;
  logic [pbvh_pkg::PRICE_W-1:0]  cfg_wdata = '0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_operation = 1'b0;
  logic                          in_side = 1'b0;
  logic [pbvh_pkg::QTY_W-1:0]    in_quantity = '0;
  logic [pbvh_pkg::PRICE_W-1:0]  in_price = '0;
  logic [pbvh_pkg::RIDX_W-1:0]   in_read_index = '0;

  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [pbvh_pkg::BUCKET_W-1:0] out_bucket;
  logic [pbvh_pkg::TOTAL_W-1:0]  out_total;
  logic                          out_saturated;

  // Predictor state: shadow of both volume stores and the base price register.
  logic [pbvh_pkg::TOTAL_W-1:0]  buy_volume  [BUCKETS];
  logic [pbvh_pkg::TOTAL_W-1:0]  sell_volume [BUCKETS];
  logic [pbvh_pkg::PRICE_W-1:0]  base_shadow = pbvh_pkg::BASE_PRICE_RST;
  int unsigned                   last_add_bucket = 0;

  tally_t pending_tallies[$];

  // Shared idling switch: when low both sides run without gaps.
  bit idle_on = 1'b1;

  int unsigned hold_cnt = 0;
  int unsigned n_adds = 0;
  int unsigned n_reads = 0;
  int unsigned n_cfg = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;

  price_bucket_volume_histogram_top #(
    .BUCKET_COUNT    (BUCKETS),
    .UNITS_PER_BUCKET(UNITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_side      (in_side),
    .in_quantity  (in_quantity),
    .in_price     (in_price),
    .in_read_index(in_read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bucket   (out_bucket),
    .out_total    (out_total),
    .out_saturated(out_saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Map a price to its bucket: round (price - base) / UNITS half away from zero,
  // then clamp to the bucket range. Prices below base land in bucket zero.
  function automatic int unsigned price_to_bucket(input logic [pbvh_pkg::PRICE_W-1:0] price);
    logic [63:0] diff;
    logic [63:0] q;
    if (price < base_shadow) begin
      return 0;
    end
    diff = 64'(price) - 64'(base_shadow);
    q = (2 * diff + 64'(UNITS)) / (2 * 64'(UNITS));
    if (q > 64'(BUCKETS - 1)) begin
      q = 64'(BUCKETS - 1);
    end
    return int'(q);
  endfunction

  // Apply one beat to the shadow stores and return the result it must produce.
  function automatic tally_t tally_order(input pbvh_pkg::op_t op, input pbvh_pkg::side_t side,
                                         input logic [pbvh_pkg::QTY_W-1:0] qty,
                                         input logic [pbvh_pkg::PRICE_W-1:0] price,
                                         input logic [pbvh_pkg::RIDX_W-1:0] ridx);
    tally_t      res;
    int unsigned b;
    logic [pbvh_pkg::TOTAL_W-1:0] t;
    if (op == pbvh_pkg::OP_ADD) begin
      b = price_to_bucket(price);
      t = (side == pbvh_pkg::SIDE_SELL) ? sell_volume[b] : buy_volume[b];
      if (t > pbvh_pkg::TOTAL_MAX - pbvh_pkg::TOTAL_W'(qty)) begin
        t = pbvh_pkg::TOTAL_MAX;
      end else begin
        t = t + pbvh_pkg::TOTAL_W'(qty);
      end
      if (side == pbvh_pkg::SIDE_SELL) begin
        sell_volume[b] = t;
      end else begin
        buy_volume[b] = t;
      end
      last_add_bucket = b;
    end else begin
      b = ridx;
      if (b < BUCKETS) begin
        t = (side == pbvh_pkg::SIDE_SELL) ? sell_volume[b] : buy_volume[b];
      end else begin
        t = '0;
      end
    end
    res.bucket    = pbvh_pkg::BUCKET_W'(b);
    res.total     = t;
    res.saturated = (t == pbvh_pkg::TOTAL_MAX);
    return res;
  endfunction

  // Send one beat: idle a random gap, present the payload, hold until taken.
  task automatic send_beat(input pbvh_pkg::op_t op, input pbvh_pkg::side_t side,
                           input logic [pbvh_pkg::QTY_W-1:0] qty,
                           input logic [pbvh_pkg::PRICE_W-1:0] price,
                           input logic [pbvh_pkg::RIDX_W-1:0] ridx);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_side       <= side;
    in_quantity   <= qty;
    in_price      <= price;
    in_read_index <= ridx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_tallies.push_back(tally_order(op, side, qty, price, ridx));
    if (op == pbvh_pkg::OP_ADD) begin
      n_adds++;
    end else begin
      n_reads++;
    end
  endtask

  // Write base_price with the block idle: drop valid, drain, let the pipe settle.
  task automatic write_base_price(input logic [pbvh_pkg::PRICE_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_shadow = value;
    n_cfg++;
  endtask

  // Result side: check each taken beat against the oldest expectation, then
  // draw how long to stall before the next one.
  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_tallies.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result beat bucket=%0d total=%0d saturated=%0b",
                   $time, out_bucket, out_total, out_saturated);
        end else begin
          want = pending_tallies.pop_front();
          n_checked++;
          if (out_bucket !== want.bucket) begin
            n_errors++;
            $display("%0t: bucket expected %0d actual %0d", $time, want.bucket, out_bucket);
          end
          if (out_total !== want.total) begin
            n_errors++;
            $display("%0t: total expected %0d actual %0d", $time, want.total, out_total);
          end
          if (out_saturated !== want.saturated) begin
            n_errors++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, out_saturated);
          end
        end
        hold_cnt = idle_on ? $urandom_range(0, 7) : 0;
        out_stall <= (hold_cnt != 0);
      end else if (out_stall) begin
        hold_cnt = hold_cnt - 1;
        out_stall <= (hold_cnt != 0);
      end
    end
  end

  // Both stores come out of the clearing pass as zero.
  task automatic test_cleared_totals();
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_BUY,  16'hFFFF, 24'hFFFFFF, 8'd0);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_SELL, 16'h0000, 24'h000000, 8'd255);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_BUY,  16'h1234, 24'h5A5A5A, 8'd128);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_SELL, 16'hFFFF, 24'hA5A5A5, 8'd1);
  endtask

  // Rounding and clamping around the reset base price.
  task automatic test_bucket_edges();
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_BUY,  16'd65535, BASE_RST,             8'hFF);
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_BUY,  16'd1,     BASE_RST + 24'd49,    8'h00);
    // half rounds up
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_SELL, 16'd7,     BASE_RST + 24'd50,    8'h00);
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_SELL, 16'd0,     BASE_RST + 24'd149,   8'h55);
    // below base
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_BUY,  16'd300,   24'd0,                8'hAA);
    // far above
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_SELL, 16'd65535, 24'hFFFFFF,           8'h00);
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_BUY,  16'd11,    BASE_RST + 24'd25449, 8'h00);
    send_beat(pbvh_pkg::OP_ADD, pbvh_pkg::SIDE_BUY,  16'd13,    BASE_RST + 24'd25450, 8'h00);
  endtask

  // Base price at both ends of its range.
  task automatic test_base_extremes();
    write_base_price(24'd0);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_BUY,  16'd65535, 24'd0,      8'd0);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_SELL, 16'd2,     24'hFFFFFF, 8'd0);
    write_base_price(24'hFFFFFF);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_BUY,  16'd5,     24'hFFFFFE, 8'd0);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_SELL, 16'd9,     24'hFFFFFF, 8'd0);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_SELL, 16'd0,     24'd0,      8'd255);
    write_base_price(BASE_RST);
  endtask

  // Back-to-back hits on one bucket exercise the forward path.
  task automatic test_same_bucket_streak();
    idle_on = 1'b0;
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_BUY,  16'd100,   BASE_RST + 24'd500, 8'd0);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_BUY,  16'd200,   BASE_RST + 24'd510, 8'd0);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_BUY,  16'd0,     24'd0,              8'd5);
    send_beat(pbvh_pkg::OP_ADD,  pbvh_pkg::SIDE_BUY,  16'd65535, BASE_RST + 24'd490, 8'd0);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_BUY,  16'd0,     24'd0,              8'd5);
    send_beat(pbvh_pkg::OP_READ, pbvh_pkg::SIDE_SELL, 16'd0,     24'd0,              8'd5);
    idle_on = 1'b1;
  endtask

  // Random traffic in phases, each with its own base price.
  task automatic test_random_traffic();
    logic [pbvh_pkg::PRICE_W-1:0] bases [6];
    int unsigned                  hot;
    int unsigned                  pick;
    logic [pbvh_pkg::PRICE_W-1:0] price;
    logic [pbvh_pkg::QTY_W-1:0]   qty;
    logic [pbvh_pkg::RIDX_W-1:0]  ridx;
    pbvh_pkg::op_t                op;
    bases[0] = pbvh_pkg::PRICE_W'($urandom);
    bases[1] = 24'd0;
    bases[2] = 24'hFFFFFF;
    bases[3] = BASE_RST;
    bases[4] = pbvh_pkg::PRICE_W'($urandom_range(0, 24'hF00000));
    bases[5] = pbvh_pkg::PRICE_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_base_price(bases[ph]);
      hot = $urandom_range(0, BUCKETS - 1);
      for (int i = 0; i < 108; i++) begin
        // Flip idling on and off in stretches of twenty beats.
        if (i % 20 == 0) begin
          idle_on = ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0: begin
            price = pbvh_pkg::PRICE_W'($urandom);
          end
          1: begin
            price = (base_shadow == 0) ? 24'd0
                    : pbvh_pkg::PRICE_W'($urandom_range(0, base_shadow - 1));
          end
          2, 3: begin
            price = base_shadow
                    + pbvh_pkg::PRICE_W'(hot * UNITS + $urandom_range(0, UNITS - 1))
                    - pbvh_pkg::PRICE_W'(UNITS / 2);
          end
          default: begin
            price = base_shadow
                    + pbvh_pkg::PRICE_W'($urandom_range(0, UNITS * BUCKETS + 2 * UNITS));
          end
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          qty = '0;
        end else if (pick == 1) begin
          qty = '1;
        end else begin
          qty = pbvh_pkg::QTY_W'($urandom_range(0, 65535));
        end
        ridx = ($urandom_range(0, 1) == 0) ? pbvh_pkg::RIDX_W'(last_add_bucket)
                                            : pbvh_pkg::RIDX_W'($urandom_range(0, 255));
        op = ($urandom_range(0, 3) == 0) ? pbvh_pkg::OP_READ : pbvh_pkg::OP_ADD;
        send_beat(op, pbvh_pkg::side_t'($urandom_range(0, 1)), qty, price, ridx);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned drain;
    for (int i = 0; i < BUCKETS; i++) begin
      buy_volume[i]  = '0;
      sell_volume[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Write the register once during the clearing pass, back to its reset value.
    write_base_price(BASE_RST);
    test_cleared_totals();
    test_bucket_edges();
    test_base_extremes();
    test_same_bucket_streak();
    test_random_traffic();
    in_valid <= 1'b0;

    // Drain what is still in flight, then let the pipe settle.
    drain = 0;
    while (pending_tallies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_tallies.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_tallies.size());
    end
    repeat (PIPE_CYCLES) @(posedge clk);

    $display("covered %0d order adds and %0d bucket reads over %0d base price writes",
             n_adds, n_reads, n_cfg);
    $display("%0d result beats compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2400000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pbvh_pkg.sv
hw/rtl/pbvh_ram.sv
hw/rtl/price_bucket_volume_histogram_top.sv
test/tb_price_bucket_volume_histogram_top.sv
